// File: rtl/radix_suffix_integer_literal_parser_top_defines.svh
// assertion macros for the radix suffix literal parser checks
`ifndef RADIX_SUFFIX_INTEGER_LITERAL_PARSER_TOP_DEFINES_SVH
`define RADIX_SUFFIX_INTEGER_LITERAL_PARSER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define RSILP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rsilp check failed");

// next-cycle implication, sampled on clk, off during reset
`define RSILP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rsilp check failed");

`endif

// File: rtl/rsilp_pkg.sv
// shared types and constants for the radix suffix literal parser
package rsilp_pkg;

    localparam int VALUE_WIDTH_DEFAULT = 64;
    localparam int QUEUE_DEPTH_DEFAULT = 2;
    localparam int OUT_VALUE_WIDTH     = 64;

    localparam logic [1:0] STATUS_NOT_NUMBER = 2'd0;
    localparam logic [1:0] STATUS_MALFORMED  = 2'd1;
    localparam logic [1:0] STATUS_VALID      = 2'd2;

    localparam int INV_HEX = 0;
    localparam int INV_DEC = 1;
    localparam int INV_OCT = 2;
    localparam int INV_BIN = 3;

    localparam logic [7:0] CHAR_0       = 8'h30;
    localparam logic [7:0] CHAR_9       = 8'h39;
    localparam logic [7:0] CHAR_A       = 8'h41;
    localparam logic [7:0] CHAR_F       = 8'h46;
    localparam logic [7:0] CHAR_B       = 8'h42;
    localparam logic [7:0] CHAR_D       = 8'h44;
    localparam logic [7:0] CHAR_H       = 8'h48;
    localparam logic [7:0] CHAR_O       = 8'h4f;
    localparam logic [7:0] CHAR_X       = 8'h58;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;
    localparam logic [7:0] HEX_LETTER_BASE = 8'd10;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]                 status;
        logic [OUT_VALUE_WIDTH-1:0] value;
    } out_beat_t;

    typedef struct packed {
        logic [3:0] digit;
        logic       is_digit;
        logic       is_zero;
        logic       is_x;
        logic       is_h;
        logic       is_d;
        logic       is_o;
        logic       is_b;
        logic       is_last;
    } cls_t;

endpackage

// File: rtl/rsilp_fifo.sv
// small register queue with registered full and empty flags
module rsilp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
        if (p == AW'(DEPTH - 1))
            return '0;
        else
            return p + AW'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= next_ptr(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= next_ptr(rd_ptr_reg);
            if (do_push && !do_pop)
                count_reg <= count_reg + CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

// File: rtl/rsilp_front.sv
// front end: folds case, classifies each character and queues it
module rsilp_front #(
    parameter int QUEUE_DEPTH = rsilp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rsilp_pkg::in_beat_t char_beat,
    output logic               full,
    input  logic               cls_pop,
    output rsilp_pkg::cls_t    cls,
    output logic               cls_empty
);

    import rsilp_pkg::*;

    logic [7:0] upper;
    cls_t       cls_in;

    always_comb
    begin
        upper = char_beat.char_code;
        if (upper >= CHAR_LOWER_A && upper <= CHAR_LOWER_Z)
            upper = upper - CASE_OFFSET;

        cls_in          = '0;
        cls_in.is_last  = char_beat.is_last;
        cls_in.is_zero  = (upper == CHAR_0);
        cls_in.is_x     = (upper == CHAR_X);
        cls_in.is_h     = (upper == CHAR_H);
        cls_in.is_d     = (upper == CHAR_D);
        cls_in.is_o     = (upper == CHAR_O);
        cls_in.is_b     = (upper == CHAR_B);
        if (upper >= CHAR_0 && upper <= CHAR_9)
        begin
            cls_in.is_digit = 1'b1;
            cls_in.digit    = 4'(upper - CHAR_0);
        end
        else if (upper >= CHAR_A && upper <= CHAR_F)
        begin
            cls_in.is_digit = 1'b1;
            cls_in.digit    = 4'(upper - CHAR_A + HEX_LETTER_BASE);
        end
    end

    rsilp_fifo #(
        .WIDTH ($bits(cls_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cls_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cls_in),
        .full  (full),
        .pop   (cls_pop),
        .rdata (cls),
        .empty (cls_empty)
    );

endmodule

// File: rtl/rsilp_back.sv
// back end: runs the four radix accumulators and forms the result
module rsilp_back #(
    parameter int VALUE_WIDTH = rsilp_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rsilp_pkg::cls_t      cls,
    input  logic                 cls_empty,
    output logic                 cls_pop,
    input  logic                 res_full,
    output logic                 res_push,
    output rsilp_pkg::out_beat_t res
);

    import rsilp_pkg::*;

    localparam int W  = VALUE_WIDTH;
    localparam int WH = VALUE_WIDTH + 4;
    localparam int WO = VALUE_WIDTH + 3;
    localparam int WB = VALUE_WIDTH + 1;

    logic [1:0]   char_pos_reg,   char_pos_next;
    logic         first_zero_reg, first_zero_next;
    logic         hex_mode_reg,   hex_mode_next;
    logic         shape_inv_reg,  shape_inv_next;
    logic [W-1:0] hex_acc_reg,    hex_acc_next;
    logic [W-1:0] dec_acc_reg,    dec_acc_next;
    logic [W-1:0] oct_acc_reg,    oct_acc_next;
    logic [W-1:0] bin_acc_reg,    bin_acc_next;
    logic [3:0]   radix_inv_reg,  radix_inv_next;

    logic [WH-1:0] hex_wide;
    logic [WH-1:0] dec_wide;
    logic [WO-1:0] oct_wide;
    logic [WB-1:0] bin_wide;
    logic          hex_ok;
    logic          dec_ok;
    logic          oct_ok;
    logic          bin_ok;
    logic          advance;

    assign hex_wide = {hex_acc_reg, 4'b0} + WH'(cls.digit);
    assign dec_wide = {1'b0, dec_acc_reg, 3'b0} + {3'b0, dec_acc_reg, 1'b0} + WH'(cls.digit);
    assign oct_wide = {oct_acc_reg, 3'b0} + WO'(cls.digit);
    assign bin_wide = {bin_acc_reg, 1'b0} + WB'(cls.digit);

    assign hex_ok = cls.is_digit && (hex_wide[WH-1:W] == 4'd0);
    assign dec_ok = cls.is_digit && (cls.digit < 4'd10) && (dec_wide[WH-1:W] == 4'd0);
    assign oct_ok = cls.is_digit && (cls.digit < 4'd8) && (oct_wide[WO-1:W] == 3'd0);
    assign bin_ok = cls.is_digit && (cls.digit < 4'd2) && !bin_wide[W];

    assign advance  = !cls_empty && (!cls.is_last || !res_full);
    assign cls_pop  = advance;
    assign res_push = advance && cls.is_last;

    always_comb
    begin
        logic [W-1:0] sel_acc;
        logic         sel_bad;
        logic         decided;
        logic [1:0]   status;

        char_pos_next   = char_pos_reg;
        first_zero_next = first_zero_reg;
        hex_mode_next   = hex_mode_reg;
        shape_inv_next  = shape_inv_reg;
        hex_acc_next    = hex_acc_reg;
        dec_acc_next    = dec_acc_reg;
        oct_acc_next    = oct_acc_reg;
        bin_acc_next    = bin_acc_reg;
        radix_inv_next  = radix_inv_reg;
        sel_acc         = '0;
        sel_bad         = 1'b0;
        decided         = 1'b0;
        status          = STATUS_NOT_NUMBER;

        if (!cls.is_last)
        begin
            if (char_pos_reg == 2'd0)
            begin
                if (!cls.is_digit)
                    shape_inv_next = 1'b1;
                first_zero_next = cls.is_zero;
            end
            else if (char_pos_reg == 2'd1 && first_zero_reg && cls.is_x)
                hex_mode_next = 1'b1;
            else if (!cls.is_digit)
                shape_inv_next = 1'b1;

            if (cls.is_digit && !(char_pos_reg == 2'd1 && first_zero_reg && cls.is_x))
            begin
                if (hex_ok)
                    hex_acc_next = hex_wide[W-1:0];
                else
                    radix_inv_next[INV_HEX] = 1'b1;
                if (dec_ok)
                    dec_acc_next = dec_wide[W-1:0];
                else
                    radix_inv_next[INV_DEC] = 1'b1;
                if (oct_ok)
                    oct_acc_next = oct_wide[W-1:0];
                else
                    radix_inv_next[INV_OCT] = 1'b1;
                if (bin_ok)
                    bin_acc_next = bin_wide[W-1:0];
                else
                    radix_inv_next[INV_BIN] = 1'b1;
            end

            if (char_pos_reg != 2'd2)
                char_pos_next = char_pos_reg + 2'd1;
        end
        else
        begin
            if (char_pos_reg == 2'd0)
            begin
                if (cls.is_digit)
                begin
                    sel_acc = dec_wide[W-1:0];
                    sel_bad = radix_inv_reg[INV_DEC] || !dec_ok;
                    decided = 1'b1;
                end
            end
            else if (char_pos_reg == 2'd1 && first_zero_reg && cls.is_x)
                status = STATUS_MALFORMED;
            else if (hex_mode_reg)
            begin
                if (cls.is_digit)
                begin
                    sel_acc = hex_wide[W-1:0];
                    sel_bad = radix_inv_reg[INV_HEX] || !hex_ok;
                    decided = 1'b1;
                end
                else if (cls.is_h || cls.is_o)
                    status = STATUS_MALFORMED;
            end
            else if (cls.is_h)
            begin
                sel_acc = hex_acc_reg;
                sel_bad = radix_inv_reg[INV_HEX];
                decided = 1'b1;
            end
            else if (cls.is_d)
            begin
                sel_acc = dec_acc_reg;
                sel_bad = radix_inv_reg[INV_DEC];
                decided = 1'b1;
            end
            else if (cls.is_o)
            begin
                sel_acc = oct_acc_reg;
                sel_bad = radix_inv_reg[INV_OCT];
                decided = 1'b1;
            end
            else if (cls.is_b)
            begin
                sel_acc = bin_acc_reg;
                sel_bad = radix_inv_reg[INV_BIN];
                decided = 1'b1;
            end
            else if (cls.is_digit)
            begin
                sel_acc = dec_wide[W-1:0];
                sel_bad = radix_inv_reg[INV_DEC] || !dec_ok;
                decided = 1'b1;
            end

            if (decided)
                status = sel_bad ? STATUS_MALFORMED : STATUS_VALID;

            char_pos_next   = 2'd0;
            first_zero_next = 1'b0;
            hex_mode_next   = 1'b0;
            shape_inv_next  = 1'b0;
            hex_acc_next    = '0;
            dec_acc_next    = '0;
            oct_acc_next    = '0;
            bin_acc_next    = '0;
            radix_inv_next  = '0;
        end

        res.status = STATUS_NOT_NUMBER;
        res.value  = '0;
        if (!shape_inv_reg)
        begin
            res.status = status;
            if (status == STATUS_VALID)
                res.value = OUT_VALUE_WIDTH'(sel_acc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_pos_reg   <= '0;
            first_zero_reg <= 1'b0;
            hex_mode_reg   <= 1'b0;
            shape_inv_reg  <= 1'b0;
            hex_acc_reg    <= '0;
            dec_acc_reg    <= '0;
            oct_acc_reg    <= '0;
            bin_acc_reg    <= '0;
            radix_inv_reg  <= '0;
        end
        else if (advance)
        begin
            char_pos_reg   <= char_pos_next;
            first_zero_reg <= first_zero_next;
            hex_mode_reg   <= hex_mode_next;
            shape_inv_reg  <= shape_inv_next;
            hex_acc_reg    <= hex_acc_next;
            dec_acc_reg    <= dec_acc_next;
            oct_acc_reg    <= oct_acc_next;
            bin_acc_reg    <= bin_acc_next;
            radix_inv_reg  <= radix_inv_next;
        end
    end

endmodule

// File: rtl/radix_suffix_integer_literal_parser_top.sv
// top level of the radix suffix integer literal parser
//
//  channel     | handshake        | beat
//  ------------+------------------+-------------------------------
//  char_beat   | push / full      | char_code[7:0], is_last
//  result      | empty / pop      | status[1:0], value[63:0]
//
// one character per cycle sustained while full is low; a character is
// classified on entry and reaches the accumulators through the class queue
// a result is queued as its last character leaves the accumulator stage and
// shows on the ports from the head of the result queue
// full and empty are registered; a stalled result side fills both queues first
// reset clears all parser state and both queues
module radix_suffix_integer_literal_parser_top #(
    parameter int VALUE_WIDTH = rsilp_pkg::VALUE_WIDTH_DEFAULT,
    parameter int QUEUE_DEPTH = rsilp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rsilp_pkg::in_beat_t  char_beat,
    output logic                 full,
    input  logic                 pop,
    output rsilp_pkg::out_beat_t result,
    output logic                 empty
);

    import rsilp_pkg::*;

    cls_t      cls;
    logic      cls_empty;
    logic      cls_pop;
    out_beat_t res;
    logic      res_push;
    logic      res_full;

    rsilp_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .char_beat (char_beat),
        .full      (full),
        .cls_pop   (cls_pop),
        .cls       (cls),
        .cls_empty (cls_empty)
    );

    rsilp_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls       (cls),
        .cls_empty (cls_empty),
        .cls_pop   (cls_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res)
    );

    rsilp_fifo #(
        .WIDTH ($bits(out_beat_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

// File: rtl/rsilp_checker.sv
// port-level checks for the radix suffix literal parser, bound to the top
`include "radix_suffix_integer_literal_parser_top_defines.svh"

module rsilp_checker #(
    parameter int VALUE_WIDTH = rsilp_pkg::VALUE_WIDTH_DEFAULT
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 push,
    input rsilp_pkg::in_beat_t  char_beat,
    input logic                 full,
    input logic                 pop,
    input rsilp_pkg::out_beat_t result,
    input logic                 empty
);

    import rsilp_pkg::*;

    logic unused_in;
    assign unused_in = push ^ full ^ (^char_beat);

    `RSILP_ASSERT_NOW(status_code_ok, !empty, result.status <= STATUS_VALID)
    `RSILP_ASSERT_NOW(value_zero_else, !empty && result.status != STATUS_VALID, result.value == '0)
    `RSILP_ASSERT_NOW(value_in_width, !empty, (result.value >> VALUE_WIDTH) == '0)
    `RSILP_ASSERT_NEXT(result_held, !empty && !pop, !empty && $stable(result))

endmodule

bind radix_suffix_integer_literal_parser_top rsilp_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_checker (.*);
